// ----- design/rsfs_pkg.sv -----
// shared types, level constants and lookup functions for the rgb spectral factor split
// used by every module of the pipeline; no dependencies
package rsfs_pkg;

    localparam int unsigned NUM_LVL = 4;
    localparam int unsigned DIV_STG = 4;

    typedef struct packed {
        logic [15:0]      w;
        logic [15:0]      rr;
        logic [15:0]      gg;
        logic [15:0]      bb;
        logic [2:0]       h1;
        logic [2:0]       h2;
        logic [16:0]      f1;
        logic [15:0]      f2;
        logic             pw;
        logic             pc;
        logic [3:0][19:0] ps;
        logic [2:0]       lvl;
        logic [18:0]      l1;
        logic [18:0]      l2;
        logic [18:0]      hi1;
        logic [18:0]      hi2;
        logic [19:0]      lw;
        logic [19:0]      hw;
        logic             bl_full;
        logic             bl_zero;
        logic [19:0]      d;
        logic [19:0]      rem;
        logic [7:0]       q;
        logic [19:0]      f11;
        logic [19:0]      f12;
        logic [19:0]      f21;
        logic [19:0]      f22;
        logic [19:0]      t1;
        logic [19:0]      t2;
        logic [19:0]      t3;
        logic [19:0]      t4;
    } t_item;

    typedef struct packed {
        logic [15:0] white_rest;
        logic [17:0] second_high_weight;
        logic [4:0]  second_high_index;
        logic [17:0] second_low_weight;
        logic [4:0]  second_low_index;
        logic [17:0] first_high_weight;
        logic [4:0]  first_high_index;
        logic [17:0] first_low_weight;
        logic [4:0]  first_low_index;
    } t_result;

    // scale of the spectrum at the next higher white level, zero above the top
    function automatic logic [16:0] hi_recip(input logic [2:0] lvl);
        logic [16:0] v;
        case (lvl)
            3'd0:    v = 17'd36409;
            3'd1:    v = 17'd40960;
            3'd2:    v = 17'd65536;
            3'd3:    v = 17'd109227;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] hi_white(input logic [2:0] lvl);
        logic [14:0] v;
        case (lvl)
            3'd0:    v = 15'd3277;
            3'd1:    v = 15'd6554;
            3'd2:    v = 15'd16384;
            3'd3:    v = 15'd22938;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // scale of the lower level spectrum, unity below the first level
    function automatic logic [16:0] lo_recip(input logic [2:0] lvl);
        logic [16:0] v;
        case (lvl)
            3'd0:    v = 17'd32768;
            3'd1:    v = 17'd36409;
            3'd2:    v = 17'd40960;
            3'd3:    v = 17'd65536;
            default: v = 17'd109227;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] lo_white(input logic [2:0] lvl);
        logic [14:0] v;
        case (lvl)
            3'd0:    v = 15'd0;
            3'd1:    v = 15'd3277;
            3'd2:    v = 15'd6554;
            3'd3:    v = 15'd16384;
            default: v = 15'd22938;
        endcase
        return v;
    endfunction

endpackage

// ----- design/rsfs_front.sv -----
// front stages: common white removal, hue pick, white level products and level search
// depends on rsfs_pkg
module rsfs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [15:0]          i_red,
    input  logic [15:0]          i_green,
    input  logic [15:0]          i_blue,
    output logic                 o_valid,
    output rsfs_pkg::t_item      o_data
);

    logic [3:0]      r_vld;
    rsfs_pkg::t_item r_s0, r_s1, r_s2, r_s3;
    rsfs_pkg::t_item n_s0, n_s1, n_s2, n_s3;

    function automatic rsfs_pkg::t_item hue_pick(input rsfs_pkg::t_item x);
        rsfs_pkg::t_item y;
        logic [16:0] r, g, b;
        y = x;
        r = {1'b0, x.rr};
        g = {1'b0, x.gg};
        b = {1'b0, x.bb};
        if (r >= g && r >= b) begin
            if (g > b) begin
                if (r - g > g) begin
                    y.h1 = 3'd0; y.f1 = r; y.h2 = 3'd2; y.f2 = g[15:0];
                end else begin
                    y.h1 = 3'd1; y.f1 = g; y.h2 = 3'd0; y.f2 = 16'(r - g);
                end
            end else if (r - (b >> 1) > b) begin
                y.h1 = 3'd0; y.f1 = r; y.h2 = 3'd4; y.f2 = b[15:0];
            end else begin
                y.h1 = 3'd5;
                if (r > (b >> 1)) begin
                    y.h2 = 3'd0; y.f1 = b; y.f2 = 16'(r - (b >> 1));
                end else begin
                    y.h2 = 3'd4; y.f1 = r << 1; y.f2 = 16'(b - (r << 1));
                end
            end
        end else if (g >= r && g >= b) begin
            if (r > b) begin
                if (g - r > r) begin
                    y.h1 = 3'd2; y.f1 = g; y.h2 = 3'd0; y.f2 = r[15:0];
                end else begin
                    y.h1 = 3'd1; y.f1 = r; y.h2 = 3'd2; y.f2 = 16'(g - r);
                end
            end else if (g - b > b) begin
                y.h1 = 3'd2; y.f1 = g; y.h2 = 3'd4; y.f2 = b[15:0];
            end else begin
                y.h1 = 3'd3; y.f1 = b; y.h2 = 3'd2; y.f2 = 16'(g - b);
            end
        end else begin
            if (r > g) begin
                if (b - (r >> 1) > (r >> 1)) begin
                    y.h1 = 3'd4; y.f1 = b; y.h2 = 3'd0; y.f2 = r[15:0];
                end else begin
                    y.h1 = 3'd5;
                    if (r > (b >> 1)) begin
                        y.h2 = 3'd0; y.f1 = b; y.f2 = 16'(r - (b >> 1));
                    end else begin
                        y.h2 = 3'd4; y.f1 = r << 1; y.f2 = 16'(b - (r << 1));
                    end
                end
            end else if (b - g > g) begin
                y.h1 = 3'd4; y.f1 = b; y.h2 = 3'd2; y.f2 = g[15:0];
            end else begin
                y.h1 = 3'd3; y.f1 = g; y.h2 = 3'd4; y.f2 = 16'(b - g);
            end
        end
        y.pw = (y.f1 == 17'd0) && (y.f2 == 16'd0);
        y.pc = (x.w == 16'd0);
        return y;
    endfunction

    logic [15:0] mn;
    logic [17:0] sum;
    logic [34:0] prod_a [4];
    logic [34:0] prod_b [4];
    logic [19:0] add_v  [4];

    always_comb begin
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        n_s0 = '0;
        n_s0.w  = mn;
        n_s0.rr = i_red - mn;
        n_s0.gg = i_green - mn;
        n_s0.bb = i_blue - mn;

        n_s1 = hue_pick(r_s0);

        n_s2 = r_s1;
        sum = 18'(r_s1.f1) + 18'(r_s1.f2);
        for (int i = 0; i < rsfs_pkg::NUM_LVL; i++) begin
            prod_a[i] = 35'(sum) * 35'(rsfs_pkg::hi_recip(3'(i)));
            n_s2.ps[i] = prod_a[i][34:15];
        end

        n_s3 = r_s2;
        n_s3.lvl = 3'd4;
        for (int i = rsfs_pkg::NUM_LVL - 1; i >= 0; i--) begin
            prod_b[i] = 35'(r_s2.ps[i]) * 35'(rsfs_pkg::hi_white(3'(i)));
            add_v[i]  = prod_b[i][34:15];
            if (add_v[i] > {4'd0, r_s2.w}) begin
                n_s3.lvl = 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_vld[3];
    assign o_data  = r_s3;

endmodule

// ----- design/rsfs_level.sv -----
// level stages: lower and higher spectrum weights, their white, divider operands
// depends on rsfs_pkg
module rsfs_level (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rsfs_pkg::t_item      i_data,
    output logic                 o_valid,
    output rsfs_pkg::t_item      o_data
);

    logic [2:0]      r_vld;
    rsfs_pkg::t_item r_s0, r_s1, r_s2;
    rsfs_pkg::t_item n_s0, n_s1, n_s2;

    logic [33:0] p_l1, p_l2, p_h1, p_h2;
    logic [34:0] p_lw, p_hw;
    logic [19:0] nume;

    always_comb begin
        n_s0 = i_data;
        p_l1 = 34'(i_data.f1) * 34'(rsfs_pkg::lo_recip(i_data.lvl));
        p_l2 = 34'(i_data.f2) * 34'(rsfs_pkg::lo_recip(i_data.lvl));
        p_h1 = 34'(i_data.f1) * 34'(rsfs_pkg::hi_recip(i_data.lvl));
        p_h2 = 34'(i_data.f2) * 34'(rsfs_pkg::hi_recip(i_data.lvl));
        n_s0.l1  = p_l1[33:15];
        n_s0.l2  = p_l2[33:15];
        n_s0.hi1 = p_h1[33:15];
        n_s0.hi2 = p_h2[33:15];

        n_s1 = r_s0;
        p_lw = 35'(20'(r_s0.l1) + 20'(r_s0.l2)) * 35'(rsfs_pkg::lo_white(r_s0.lvl));
        p_hw = 35'(20'(r_s0.hi1) + 20'(r_s0.hi2)) * 35'(rsfs_pkg::hi_white(r_s0.lvl));
        n_s1.lw = p_lw[34:15];
        n_s1.hw = p_hw[34:15];

        n_s2 = r_s1;
        nume = r_s1.hw - {4'd0, r_s1.w};
        n_s2.d       = r_s1.hw - r_s1.lw;
        n_s2.bl_zero = (r_s1.hw > r_s1.lw) && (r_s1.hw <= {4'd0, r_s1.w});
        n_s2.bl_full = !(r_s1.hw > r_s1.lw)
                       || ((r_s1.hw > {4'd0, r_s1.w}) && (nume >= n_s2.d));
        n_s2.rem     = nume;
        n_s2.q       = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_vld[2];
    assign o_data  = r_s2;

endmodule

// ----- design/rsfs_div.sv -----
// restoring divider for the blend ratio, two quotient bits per stage over four stages
// depends on rsfs_pkg
module rsfs_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rsfs_pkg::t_item      i_data,
    output logic                 o_valid,
    output rsfs_pkg::t_item      o_data
);

    logic [rsfs_pkg::DIV_STG-1:0] r_vld;
    rsfs_pkg::t_item    r_st [rsfs_pkg::DIV_STG];
    rsfs_pkg::t_item    n_st [rsfs_pkg::DIV_STG];
    rsfs_pkg::t_item    cur;
    logic [20:0]        sh;

    always_comb begin
        for (int s = 0; s < rsfs_pkg::DIV_STG; s++) begin
            cur = (s == 0) ? i_data : r_st[(s == 0) ? 0 : s - 1];
            for (int k = 0; k < 2; k++) begin
                sh = {cur.rem, 1'b0};
                if (sh >= {1'b0, cur.d}) begin
                    cur.rem = 20'(sh - {1'b0, cur.d});
                    cur.q   = {cur.q[6:0], 1'b1};
                end else begin
                    cur.rem = sh[19:0];
                    cur.q   = {cur.q[6:0], 1'b0};
                end
            end
            n_st[s] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[rsfs_pkg::DIV_STG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < rsfs_pkg::DIV_STG; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_valid = r_vld[rsfs_pkg::DIV_STG-1];
    assign o_data  = r_st[rsfs_pkg::DIV_STG-1];

endmodule

// ----- design/rsfs_mix.sv -----
// mix stages: blended weights, white of each spectrum, residual white and result select
// depends on rsfs_pkg
module rsfs_mix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rsfs_pkg::t_item      i_data,
    output logic                 o_valid,
    output rsfs_pkg::t_result    o_data
);

    logic [2:0]        r_vld;
    rsfs_pkg::t_item   r_s0, r_s1;
    rsfs_pkg::t_item   n_s0, n_s1;
    rsfs_pkg::t_result r_res, n_res;

    function automatic logic [19:0] sub_clip(input logic [19:0] a, input logic [19:0] s);
        return (a > s) ? a - s : 20'd0;
    endfunction

    logic [8:0]  bl, inv;
    logic [27:0] m11, m12, m21, m22;
    logic [34:0] p1, p2, p3, p4;
    logic [19:0] wv;
    logic [4:0]  c11, c21;

    always_comb begin
        n_s0 = i_data;
        bl  = i_data.bl_full ? 9'd256 : (i_data.bl_zero ? 9'd0 : {1'b0, i_data.q});
        inv = 9'd256 - bl;
        m11 = 28'(i_data.l1)  * 28'(bl);
        m12 = 28'(i_data.hi1) * 28'(inv);
        m21 = 28'(i_data.l2)  * 28'(bl);
        m22 = 28'(i_data.hi2) * 28'(inv);
        n_s0.f11 = m11[27:8];
        n_s0.f12 = m12[27:8];
        n_s0.f21 = m21[27:8];
        n_s0.f22 = m22[27:8];

        n_s1 = r_s0;
        p1 = 35'(r_s0.f11) * 35'(rsfs_pkg::lo_white(r_s0.lvl));
        p2 = 35'(r_s0.f12) * 35'(rsfs_pkg::hi_white(r_s0.lvl));
        p3 = 35'(r_s0.f21) * 35'(rsfs_pkg::lo_white(r_s0.lvl));
        p4 = 35'(r_s0.f22) * 35'(rsfs_pkg::hi_white(r_s0.lvl));
        n_s1.t1 = p1[34:15];
        n_s1.t2 = p2[34:15];
        n_s1.t3 = p3[34:15];
        n_s1.t4 = p4[34:15];

        n_res = '0;
        wv    = '0;
        c11 = 5'(r_s1.h1) + 5'(r_s1.lvl) * 5'd6;
        c21 = 5'(r_s1.h2) + 5'(r_s1.lvl) * 5'd6;
        if (r_s1.pw) begin
            n_res.white_rest = r_s1.w;
        end else if (r_s1.pc) begin
            n_res.first_low_index   = 5'(r_s1.h1);
            n_res.first_low_weight  = 18'(r_s1.f1);
            n_res.second_low_index  = 5'(r_s1.h2);
            n_res.second_low_weight = 18'(r_s1.f2);
        end else if (r_s1.lvl == 3'd4) begin
            n_res.first_low_index   = c11;
            n_res.first_low_weight  = r_s1.l1[17:0];
            n_res.second_low_index  = c21;
            n_res.second_low_weight = r_s1.l2[17:0];
            wv = sub_clip({4'd0, r_s1.w}, r_s1.lw);
            n_res.white_rest = wv[15:0];
        end else begin
            n_res.first_low_index    = c11;
            n_res.first_low_weight   = r_s1.f11[17:0];
            n_res.first_high_index   = c11 + 5'd6;
            n_res.first_high_weight  = r_s1.f12[17:0];
            n_res.second_low_index   = c21;
            n_res.second_low_weight  = r_s1.f21[17:0];
            n_res.second_high_index  = c21 + 5'd6;
            n_res.second_high_weight = r_s1.f22[17:0];
            wv = sub_clip({4'd0, r_s1.w}, r_s1.t1);
            wv = sub_clip(wv, r_s1.t2);
            wv = sub_clip(wv, r_s1.t3);
            wv = sub_clip(wv, r_s1.t4);
            n_res.white_rest = wv[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0  <= n_s0;
            r_s1  <= n_s1;
            r_res <= n_res;
        end
    end

    assign o_valid = r_vld[2];
    assign o_data  = r_res;

endmodule

// ----- design/rgb_spectral_factor_split_core.sv -----
// rgb spectral factor split: one pixel beat in, one result beat out, fourteen stages
// one beat per cycle sustained while the receiver takes each output beat
// the stage count is set by the eight-bit blend divider (two bits per stage) and the multipliers
// all stages hold together while the output beat waits; tready is low only then
// reset (synchronous, active low) clears the stage valid bits only
// depends on rsfs_pkg, rsfs_front, rsfs_level, rsfs_div, rsfs_mix
module rgb_spectral_factor_split_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,  // red, green, blue
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // first_low_index, first_low_weight, first_high_index, first_high_weight,
    // second_low_index, second_low_weight, second_high_index, second_high_weight,
    // white_rest, zero fill
    output logic [111:0] o_m_axis_tdata
);

    logic              en;
    logic              v_front, v_level, v_div;
    rsfs_pkg::t_item   d_front, d_level, d_div;
    rsfs_pkg::t_result res;

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    rsfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_red   (i_s_axis_tdata[15:0]),
        .i_green (i_s_axis_tdata[31:16]),
        .i_blue  (i_s_axis_tdata[47:32]),
        .o_valid (v_front),
        .o_data  (d_front)
    );

    rsfs_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_front),
        .i_data  (d_front),
        .o_valid (v_level),
        .o_data  (d_level)
    );

    rsfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_level),
        .i_data  (d_level),
        .o_valid (v_div),
        .o_data  (d_div)
    );

    rsfs_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_div),
        .i_data  (d_div),
        .o_valid (o_m_axis_tvalid),
        .o_data  (res)
    );

    assign o_m_axis_tdata = {4'd0, res};

endmodule

// ----- verif/rgb_spectral_factor_split_core_chk.sv -----
// checker for rgb_spectral_factor_split_core: predicts each result beat from the pixel beat
// and compares field by field; depends on rsfs_pkg for the result layout
`timescale 1ns / 100ps
module rgb_spectral_factor_split_core_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [111:0] i_m_axis_tdata,
    output int           o_errors,
    output int           o_pending
);

    rsfs_pkg::t_result split_q[$];
    int err_cnt = 0;

    function automatic longint unsigned lvl_white(input int k);
        case (k)
            0: return 3277;
            1: return 6554;
            2: return 16384;
            default: return 22938;
        endcase
    endfunction

    function automatic longint unsigned lvl_recip(input int k);
        case (k)
            0: return 36409;
            1: return 40960;
            2: return 65536;
            default: return 109227;
        endcase
    endfunction

    function automatic longint unsigned clip_sub(input longint unsigned a,
                                                 input longint unsigned s);
        return (a > s) ? a - s : 0;
    endfunction

    function automatic rsfs_pkg::t_result split_pixel(input logic [47:0] px);
        rsfs_pkg::t_result res;
        longint unsigned r, g, b, w, h1, h2, f1, f2;
        longint unsigned c11, c12, c21, c22, f11, f12, f21, f22;
        longint unsigned l1, l2, lw, hi1, hi2, hw, bl, add;
        int lvl;
        r = 64'(px[15:0]); g = 64'(px[31:16]); b = 64'(px[47:32]);
        c12 = 0; c22 = 0; f12 = 0; f22 = 0; lvl = 0;
        w = (r < g) ? r : g;
        if (b < w) w = b;
        r = r - w; g = g - w; b = b - w;
        if (r >= g && r >= b) begin
            if (g > b) begin
                if (r - g > g) begin h1 = 0; f1 = r; h2 = 2; f2 = g; end
                else begin h1 = 1; f1 = g; h2 = 0; f2 = r - g; end
            end else if (r - b / 2 > b) begin
                h1 = 0; f1 = r; h2 = 4; f2 = b;
            end else begin
                h1 = 5;
                if (r > b / 2) begin h2 = 0; f1 = b; f2 = r - b / 2; end
                else begin h2 = 4; f1 = r * 2; f2 = b - r * 2; end
            end
        end else if (g >= r && g >= b) begin
            if (r > b) begin
                if (g - r > r) begin h1 = 2; f1 = g; h2 = 0; f2 = r; end
                else begin h1 = 1; f1 = r; h2 = 2; f2 = g - r; end
            end else if (g - b > b) begin
                h1 = 2; f1 = g; h2 = 4; f2 = b;
            end else begin
                h1 = 3; f1 = b; h2 = 2; f2 = g - b;
            end
        end else begin
            if (r > g) begin
                if (b - r / 2 > r / 2) begin h1 = 4; f1 = b; h2 = 0; f2 = r; end
                else begin
                    h1 = 5;
                    if (r > b / 2) begin h2 = 0; f1 = b; f2 = r - b / 2; end
                    else begin h2 = 4; f1 = r * 2; f2 = b - r * 2; end
                end
            end else if (b - g > g) begin
                h1 = 4; f1 = b; h2 = 2; f2 = g;
            end else begin
                h1 = 3; f1 = g; h2 = 4; f2 = b - g;
            end
        end
        c11 = h1; f11 = f1; c21 = h2; f21 = f2;
        if (f1 == 0 && f2 == 0) begin
            c11 = 0; c21 = 0;
        end else if (w != 0) begin
            for (int k = 0; k < 4; k++) begin
                add = ((((f1 + f2) * lvl_recip(k)) >> 15) * lvl_white(k)) >> 15;
                if (add > w) break;
                lvl = k + 1;
            end
            l1 = (lvl > 0) ? (f1 * lvl_recip(lvl - 1)) >> 15 : f1;
            l2 = (lvl > 0) ? (f2 * lvl_recip(lvl - 1)) >> 15 : f2;
            lw = (lvl > 0) ? (lvl_white(lvl - 1) * (l1 + l2)) >> 15 : 0;
            if (lvl >= 4) begin
                c11 = h1 + 24; f11 = l1;
                c21 = h2 + 24; f21 = l2;
                w = clip_sub(w, lw);
            end else begin
                hi1 = (f1 * lvl_recip(lvl)) >> 15;
                hi2 = (f2 * lvl_recip(lvl)) >> 15;
                hw = (lvl_white(lvl) * (hi1 + hi2)) >> 15;
                if (hw > lw) begin
                    bl = (hw > w) ? (256 * (hw - w)) / (hw - lw) : 0;
                    if (bl > 256) bl = 256;
                end else begin
                    bl = 256;
                end
                f11 = (l1 * bl) >> 8;
                f12 = (hi1 * (256 - bl)) >> 8;
                f21 = (l2 * bl) >> 8;
                f22 = (hi2 * (256 - bl)) >> 8;
                w = clip_sub(w, (lvl > 0) ? (f11 * lvl_white(lvl - 1)) >> 15 : 0);
                w = clip_sub(w, (f12 * lvl_white(lvl)) >> 15);
                w = clip_sub(w, (lvl > 0) ? (f21 * lvl_white(lvl - 1)) >> 15 : 0);
                w = clip_sub(w, (f22 * lvl_white(lvl)) >> 15);
                c11 = h1 + 6 * lvl; c12 = c11 + 6;
                c21 = h2 + 6 * lvl; c22 = c21 + 6;
            end
        end else begin
            w = 0;
        end
        res.first_low_index    = c11[4:0];
        res.first_low_weight   = f11[17:0];
        res.first_high_index   = c12[4:0];
        res.first_high_weight  = f12[17:0];
        res.second_low_index   = c21[4:0];
        res.second_low_weight  = f21[17:0];
        res.second_high_index  = c22[4:0];
        res.second_high_weight = f22[17:0];
        res.white_rest         = w[15:0];
        return res;
    endfunction

    task automatic cmp_field(input string nm, input longint unsigned e, input longint unsigned a);
        if (e != a) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, nm, e, a);
            err_cnt++;
        end
    endtask

    assign o_pending = split_q.size();
    assign o_errors  = err_cnt;

    always @(posedge i_clk) begin
        rsfs_pkg::t_result e, a;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                split_q.insert(split_q.size(), split_pixel(i_s_axis_tdata));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                a = i_m_axis_tdata[107:0];
                if (split_q.size() == 0) begin
                    $display("%0t unexpected result beat %h", $time, i_m_axis_tdata);
                    err_cnt++;
                end else begin
                    e = split_q.pop_front();
                    cmp_field("first_low_index", e.first_low_index, a.first_low_index);
                    cmp_field("first_low_weight", e.first_low_weight, a.first_low_weight);
                    cmp_field("first_high_index", e.first_high_index, a.first_high_index);
                    cmp_field("first_high_weight", e.first_high_weight, a.first_high_weight);
                    cmp_field("second_low_index", e.second_low_index, a.second_low_index);
                    cmp_field("second_low_weight", e.second_low_weight, a.second_low_weight);
                    cmp_field("second_high_index", e.second_high_index, a.second_high_index);
                    cmp_field("second_high_weight", e.second_high_weight,
                              a.second_high_weight);
                    cmp_field("white_rest", e.white_rest, a.white_rest);
                    cmp_field("zero_fill", 0, 64'(i_m_axis_tdata[111:108]));
                end
            end
        end
    end
endmodule

// ----- verif/rgb_spectral_factor_split_core_tb.sv -----
// testbench top for rgb_spectral_factor_split_core: drives directed and random pixel beats
// with bursty input and stalling output; depends on the core and rgb_spectral_factor_split_core_chk
`timescale 1ns / 100ps
module rgb_spectral_factor_split_core_tb;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    int           errors;
    int           pending;
    int           cycles;
    bit           hold_off;
    bit           held;

    rgb_spectral_factor_split_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    rgb_spectral_factor_split_core_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 200000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        m_tready = 1'b0;
        held     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off && !held) begin
                m_tready <= 1'b0;
                held = 1'b1;
                repeat (60) @(posedge i_clk);
            end
            mode = (cycles / 300) % 3;
            if (mode == 0) m_tready <= 1'b1;
            else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 1) != 0);
        end
    end

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hffff;
            3: return 16'($urandom_range(0, 64));
            4: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        s_tdata  <= 48'({$urandom, $urandom});
        @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] base, r, g, b;
        int burst;
        hold_off = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        i_rst_n  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pure white, pure colors, extremes, and each hue region
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'd32768, 16'd32768, 16'd32768);
        send_pixel(16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'd32768, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd32768, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd32768);
        send_pixel(16'd32768, 16'd32768, 16'd0);
        send_pixel(16'd0, 16'd32768, 16'd32768);
        send_pixel(16'd32768, 16'd0, 16'd32768);
        send_pixel(16'd32768, 16'd10000, 16'd0);
        send_pixel(16'd10000, 16'd32768, 16'd0);
        send_pixel(16'd0, 16'd10000, 16'd32768);
        send_pixel(16'd32768, 16'd0, 16'd20000);
        send_pixel(16'd10000, 16'd0, 16'd32768);
        send_pixel(16'd20000, 16'd0, 16'd32768);
        send_pixel(16'd32768, 16'd2000, 16'd2000);
        send_pixel(16'd30000, 16'd30000, 16'd29000);
        send_pixel(16'd32768, 16'd20000, 16'd20000);
        send_pixel(16'd12000, 16'd2000, 16'd2000);
        send_pixel(16'hffff, 16'd0, 16'h8000);
        send_pixel(16'd1, 16'd0, 16'd0);
        go_idle();

        // wait for the pipeline to drain
        while (pending != 0) @(posedge i_clk);

        // long receiver hold-off while beats keep coming
        hold_off = 1'b1;
        for (int k = 0; k < 40; k++) send_pixel(rand_chan(), rand_chan(), rand_chan());
        go_idle();

        for (int n = 0; n < 1400; n += burst) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    base = 16'($urandom_range(0, 32768));
                    r = 16'(base + $urandom_range(0, 4000));
                    g = 16'(base + $urandom_range(0, 4000));
                    b = 16'(base + $urandom_range(0, 4000));
                    send_pixel(r, g, b);
                end else begin
                    send_pixel(rand_chan(), rand_chan(), rand_chan());
                end
            end
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) go_idle();
        end
        go_idle();

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- rgb_spectral_factor_split_core.f -----
design/rsfs_pkg.sv
design/rsfs_front.sv
design/rsfs_level.sv
design/rsfs_div.sv
design/rsfs_mix.sv
design/rgb_spectral_factor_split_core.sv
verif/rgb_spectral_factor_split_core_chk.sv
verif/rgb_spectral_factor_split_core_tb.sv
